@@ design/sprite_entry_tile_expander_top_assert.svh @@
// ============================================================================
// Sprite entry tile expander assertion macros
// Implication checks on the rising clock edge, masked while reset is low.
// ============================================================================
`ifndef SPRITE_ENTRY_TILE_EXPANDER_TOP_ASSERT_SVH
`define SPRITE_ENTRY_TILE_EXPANDER_TOP_ASSERT_SVH

// same-cycle implication
`define SETE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sete assertion failed");

// next-cycle implication
`define SETE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sete assertion failed");

`endif

@@ design/sete_pkg.sv @@
// ============================================================================
// Sprite entry tile expander package
// Widths, shape codes, position constants and the job record for the queue.
// ============================================================================
`timescale 1ns / 1ps

package sete_pkg;

    localparam int CODE_W = 14;
    localparam int POS_W  = 10;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    localparam logic [ADDR_W-1:0] REG_SCREEN_FLIPPED = 3'd0;

    localparam logic [1:0] SHP_SINGLE = 2'd0;
    localparam logic [1:0] SHP_HPAIR  = 2'd1;
    localparam logic [1:0] SHP_VPAIR  = 2'd2;
    localparam logic [1:0] SHP_QUAD   = 2'd3;

    localparam logic [POS_W-1:0] X_BIAS        = 10'd33;
    localparam logic [POS_W-1:0] QUAD_FLIP_X   = 10'd256;
    localparam logic [POS_W-1:0] QUAD_FLIP_Y   = 10'd224;
    localparam logic [POS_W-1:0] WIDE_FLIP_X   = 10'd280;
    localparam logic [POS_W-1:0] NARROW_FLIP_X = 10'd272;
    localparam logic [POS_W-1:0] TALL_FLIP_Y   = 10'd248;
    localparam logic [POS_W-1:0] SHORT_FLIP_Y  = 10'd240;
    localparam logic [POS_W-1:0] OFS_LARGE     = 10'd16;
    localparam logic [POS_W-1:0] OFS_SMALL     = 10'd8;

    typedef struct packed {
        logic              small_set;
        logic [CODE_W-1:0] code;
        logic [3:0]        color;
        logic              fx;
        logic              fy;
        logic [POS_W-1:0]  sx;
        logic [POS_W-1:0]  sy;
        logic [1:0]        shape;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

@@ design/sete_if.sv @@
// ============================================================================
// Sprite entry tile expander channels
// Entry request channel and tile command channel, valid/ready handshake.
// ============================================================================
`timescale 1ns / 1ps

interface sete_ent_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_low_byte;
    logic [7:0] code_color_byte;
    logic [7:0] y_byte;
    logic [7:0] x_byte;
    logic [7:0] attr_byte;

    modport source (output valid, code_low_byte, code_color_byte, y_byte, x_byte,
                    attr_byte, input ready);
    modport sink   (input valid, code_low_byte, code_color_byte, y_byte, x_byte,
                    attr_byte, output ready);
endinterface

interface sete_cmd_if;
    logic               valid;
    logic               ready;
    logic               small_tile_set;
    logic [13:0]        tile_code;
    logic [3:0]         palette_color;
    logic               mirror_x;
    logic               mirror_y;
    logic signed [9:0]  pos_x;
    logic signed [9:0]  pos_y;
    logic               final_tile;

    modport source (output valid, small_tile_set, tile_code, palette_color, mirror_x,
                    mirror_y, pos_x, pos_y, final_tile, input ready);
    modport sink   (input valid, small_tile_set, tile_code, palette_color, mirror_x,
                    mirror_y, pos_x, pos_y, final_tile, output ready);
endinterface

@@ design/sete_front.sv @@
// ============================================================================
// Sprite entry tile expander front end
// Accept an entry, classify its size, apply screen flip, build a job.
// ============================================================================
`timescale 1ns / 1ps

module sete_front
    import sete_pkg::*;
(
    input  logic    i_flip,
    sete_ent_if.sink i_ent,
    input  t_q_stat i_q_stat,
    output logic    o_push,
    output t_job    o_job
);

    logic [11:0]      code12;
    logic [2:0]       size;
    logic [POS_W-1:0] sx0;
    logic [POS_W-1:0] sy0;
    logic [POS_W-1:0] kx;
    logic [POS_W-1:0] ky;

    assign code12 = {i_ent.code_color_byte[3:0], i_ent.code_low_byte};
    assign size   = i_ent.attr_byte[4:2];
    assign sx0    = X_BIAS + {2'b00, i_ent.x_byte} - {1'b0, i_ent.attr_byte[0], 8'h00};
    assign sy0    = {2'b00, i_ent.y_byte};

    always_comb begin
        o_job.color = i_ent.code_color_byte[7:4];
        o_job.fx    = i_ent.attr_byte[5] ^ i_flip;
        o_job.fy    = i_ent.attr_byte[6] ^ i_flip;
        if (size[2]) begin
            o_job.shape     = SHP_QUAD;
            o_job.small_set = 1'b0;
            o_job.code      = {2'b00, code12};
            kx              = QUAD_FLIP_X;
            ky              = QUAD_FLIP_Y;
        end else begin
            kx = size[1] ? WIDE_FLIP_X : NARROW_FLIP_X;
            ky = size[0] ? TALL_FLIP_Y : SHORT_FLIP_Y;
            o_job.small_set = 1'b1;
            o_job.code      = {2'b00, code12[9:0], code12[11:10]};
            unique case (size[1:0])
                2'd0: begin
                    o_job.shape     = SHP_SINGLE;
                    o_job.small_set = 1'b0;
                    o_job.code      = {2'b00, code12};
                end
                2'd1:    o_job.shape = SHP_HPAIR;
                2'd2:    o_job.shape = SHP_VPAIR;
                default: o_job.shape = SHP_SINGLE;
            endcase
        end
        o_job.sx = i_flip ? (kx - sx0) : sx0;
        o_job.sy = i_flip ? (ky - sy0) : sy0;
    end

    assign i_ent.ready = !i_q_stat.full;
    assign o_push      = i_ent.valid && !i_q_stat.full;

endmodule

@@ design/sete_queue.sv @@
// ============================================================================
// Sprite entry tile expander job queue
// Two-entry FIFO of classified jobs between front and back ends.
// ============================================================================
`timescale 1ns / 1ps

module sete_queue
    import sete_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_head,
    output t_q_stat o_stat
);

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_head       = r_mem[r_rd];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));

endmodule

@@ design/sete_back.sv @@
// ============================================================================
// Sprite entry tile expander back end
// Step a job's tiles into the output reg, one per cycle unless stalled.
// ============================================================================
`timescale 1ns / 1ps

module sete_back
    import sete_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_head,
    input  t_q_stat   i_q_stat,
    output logic      o_pop,
    sete_cmd_if.source o_cmd
);

    t_job              r_job;
    logic              r_busy;
    logic [1:0]        r_idx;
    logic              r_vld;
    logic              r_small;
    logic [CODE_W-1:0] r_code;
    logic [3:0]        r_color;
    logic              r_fx;
    logic              r_fy;
    logic [POS_W-1:0]  r_x;
    logic [POS_W-1:0]  r_y;
    logic              r_last;

    t_job              cur;
    logic [1:0]        idx;
    logic              load;
    logic              last;
    logic [CODE_W-1:0] n_code;
    logic [POS_W-1:0]  n_x;
    logic [POS_W-1:0]  n_y;

    assign cur  = r_busy ? r_job : i_head;
    assign idx  = r_busy ? r_idx : 2'd0;
    assign load = (r_busy || !i_q_stat.empty) && (!r_vld || o_cmd.ready);

    always_comb begin
        n_code = cur.code;
        n_x    = cur.sx;
        n_y    = cur.sy;
        last   = 1'b1;
        unique case (cur.shape)
            SHP_QUAD: begin
                n_code = cur.code + {{(CODE_W-2){1'b0}}, idx};
                n_x    = cur.sx + ((idx[0] ^ cur.fx) ? OFS_LARGE : '0);
                n_y    = cur.sy + ((idx[1] ^ cur.fy) ? OFS_LARGE : '0);
                last   = (idx == 2'd3);
            end
            SHP_HPAIR: begin
                n_code = {cur.code[CODE_W-1:1], idx[0]};
                n_x    = cur.sx + ((idx[0] ^ cur.fx) ? OFS_SMALL : '0);
                last   = idx[0];
            end
            SHP_VPAIR: begin
                n_code = {cur.code[CODE_W-1:2], idx[0], cur.code[0]};
                n_y    = cur.sy + ((idx[0] ^ cur.fy) ? OFS_SMALL : '0);
                last   = idx[0];
            end
            default: last = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_vld  <= 1'b0;
        end else if (load) begin
            r_vld <= 1'b1;
            if (last) begin
                r_busy <= 1'b0;
            end else if (!r_busy) begin
                r_busy <= 1'b1;
                r_idx  <= 2'd1;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end else if (o_cmd.ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (!r_busy) begin
                r_job <= i_head;
            end
            r_small <= cur.small_set;
            r_code  <= n_code;
            r_color <= cur.color;
            r_fx    <= cur.fx;
            r_fy    <= cur.fy;
            r_x     <= n_x;
            r_y     <= n_y;
            r_last  <= last;
        end
    end

    assign o_pop                = load && !r_busy;
    assign o_cmd.valid          = r_vld;
    assign o_cmd.small_tile_set = r_small;
    assign o_cmd.tile_code      = r_code;
    assign o_cmd.palette_color  = r_color;
    assign o_cmd.mirror_x       = r_fx;
    assign o_cmd.mirror_y       = r_fy;
    assign o_cmd.pos_x          = $signed(r_x);
    assign o_cmd.pos_y          = $signed(r_y);
    assign o_cmd.final_tile     = r_last;

endmodule

@@ design/sprite_entry_tile_expander_top.sv @@
// ============================================================================
// Sprite entry tile expander
// Each five-byte sprite entry becomes one, two or four tile commands, one
// command leaving per cycle while the output is not stalled. A 32x32 entry
// gives four, 16x8 and 8x16 two, the rest one. The back end's tile counter
// steps through them; a two-entry job queue lets new entries be taken while
// it works. Register 0 (screen_flipped, byte address 0) mirrors positions
// and inverts flips; write it only while the block is idle.
// ============================================================================
`timescale 1ns / 1ps

module sprite_entry_tile_expander_top
    import sete_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [DATA_W-1:0] i_pwdata,
    output logic [DATA_W-1:0] o_prdata,
    output logic              o_pready,
    sete_ent_if.sink          i_ent,
    sete_cmd_if.source        o_cmd
);

    logic    r_screen_flipped;
    logic    cfg_wr;
    logic    q_push;
    logic    q_pop;
    t_job    front_job;
    t_job    q_head;
    t_q_stat q_stat;

    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite
                      && (i_paddr[ADDR_W-1:2] == REG_SCREEN_FLIPPED[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_flipped <= 1'b0;
        end else if (cfg_wr) begin
            r_screen_flipped <= i_pwdata[0];
        end
    end

    always_comb begin
        o_prdata = '0;
        if (i_paddr[ADDR_W-1:2] == REG_SCREEN_FLIPPED[ADDR_W-1:2]) begin
            o_prdata[0] = r_screen_flipped;
        end
    end

    sete_front u_front (
        .i_flip   (r_screen_flipped),
        .i_ent    (i_ent),
        .i_q_stat (q_stat),
        .o_push   (q_push),
        .o_job    (front_job)
    );

    sete_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    sete_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (q_head),
        .i_q_stat (q_stat),
        .o_pop    (q_pop),
        .o_cmd    (o_cmd)
    );

`include "sprite_entry_tile_expander_top_assert.svh"

    `SETE_ASSERT_IMP(a_no_push_full, q_push, !q_stat.full)
    `SETE_ASSERT_IMP(a_no_pop_empty, q_pop, !q_stat.empty)
    `SETE_ASSERT_NXT(a_cfg_takes, cfg_wr, r_screen_flipped == $past(i_pwdata[0]))

endmodule
